[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

// Checked only out of reset (reset is active low).
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`endif

[hdl/bdq_pkg.sv]
// ----------------------------------------------------------------------------
// bdq_pkg
// Types and fixed field widths of the bounded deque with key search.
// ----------------------------------------------------------------------------
`default_nettype none

package bdq_pkg;

  localparam int unsigned KindW       = 3;
  localparam int unsigned KeyFieldW   = 64;
  localparam int unsigned StatusW     = 2;
  localparam int unsigned CountFieldW = 5;
  localparam int unsigned OutDataW    = KeyFieldW + 1 + StatusW + CountFieldW;

  typedef enum logic [KindW-1:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_SEARCH     = 3'd4,
    KIND_REVERSE    = 3'd5
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_POP_WAIT,
    ST_SEARCH,
    ST_OUT
  } state_e;

endpackage

`default_nettype wire

[hdl/bounded_deque_with_key_search.sv]
// ----------------------------------------------------------------------------
// bounded_deque_with_key_search
// Bounded double-ended queue of keys in a ring store, with key search.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata (low bit up)                            | tuser
//  s_axis   | in  | key_value[63:0]                               | kind[2:0]
//  m_axis   | out | popped_value[63:0], found, status[1:0],       | -
//           |     | entry_count[4:0]                              |
//
//  Push, reverse and full/empty refusals pass through accept, decode and
//  result states. Pop adds a state for one registered read of the key store.
//  Search scans the stored keys between decode and result, one stored key
//  per cycle through a single comparator, fed by the store's one read port.
//  No item is accepted until the current result beat has been taken.
//  After reset the deque is empty; the key store itself is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bounded_deque_with_key_search
  import bdq_pkg::*;
#(
  parameter int unsigned CAPACITY  = 16,
  parameter int unsigned KEY_WIDTH = 64
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  wire logic [KeyFieldW-1:0] s_axis_tdata_i,   // key_value
  input  wire logic [KindW-1:0]     s_axis_tuser_i,   // kind
  output logic                      m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  // popped_value[63:0], found[64], status[66:65], entry_count[71:67]
  output logic [OutDataW-1:0]       m_axis_tdata_o
);

  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  localparam logic [CntW-1:0] CntFull = CntW'(CAPACITY);
  localparam logic [IdxW-1:0] IdxLast = IdxW'(CAPACITY - 1);

  function automatic logic [IdxW-1:0] ring_pos(input logic [IdxW-1:0] base,
                                               input logic [CntW-1:0] off);
    logic [CntW:0] sum;
    sum = (CntW+1)'(base) + (CntW+1)'(off);
    if (sum >= (CntW+1)'(CAPACITY)) begin
      sum = sum - (CntW+1)'(CAPACITY);
    end
    return sum[IdxW-1:0];
  endfunction

  state_e                state_q, state_d;
  logic [IdxW-1:0]       front_q, front_d;
  logic [CntW-1:0]       count_q, count_d;
  logic                  rev_q, rev_d;
  logic [CntW-1:0]       idx_q, idx_d;

  kind_e                 kind_q;
  logic [KEY_WIDTH-1:0]  key_q;
  logic [KEY_WIDTH-1:0]  popped_q, popped_d;
  logic                  found_q, found_d;
  status_e               status_q, status_d;

  logic [KEY_WIDTH-1:0]  mem [CAPACITY];
  logic [KEY_WIDTH-1:0]  rd_data_q;
  logic [IdxW-1:0]       rd_addr;
  logic [IdxW-1:0]       wr_addr;
  logic                  wr_en;

  logic                  s_beat;
  logic                  m_beat;
  logic                  front_side;
  logic                  is_full;
  logic                  is_empty;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = (state_q == ST_OUT);
  assign s_beat          = s_axis_tvalid_i & s_axis_tready_o;
  assign m_beat          = m_axis_tvalid_o & m_axis_tready_i;
  assign is_full         = (count_q == CntFull);
  assign is_empty        = (count_q == '0);

  always_comb begin
    unique case (kind_q)
      KIND_PUSH_FRONT: front_side = ~rev_q;
      KIND_POP_FRONT:  front_side = ~rev_q;
      default:         front_side = rev_q;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_beat) begin
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (kind_q) inside
          KIND_POP_FRONT, KIND_POP_BACK: begin
            state_d = is_empty ? ST_OUT : ST_POP_WAIT;
          end
          KIND_SEARCH: begin
            state_d = is_empty ? ST_OUT : ST_SEARCH;
          end
          default: begin
            state_d = ST_OUT;
          end
        endcase
      end
      ST_POP_WAIT: state_d = ST_OUT;
      ST_SEARCH: begin
        if (idx_q == count_q) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (m_beat) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and store control
  always_comb begin
    front_d  = front_q;
    count_d  = count_q;
    rev_d    = rev_q;
    idx_d    = idx_q;
    popped_d = popped_q;
    found_d  = found_q;
    status_d = status_q;
    rd_addr  = front_q;
    wr_addr  = front_q;
    wr_en    = 1'b0;
    unique case (state_q)
      ST_DECODE: begin
        popped_d = '0;
        found_d  = 1'b0;
        status_d = STATUS_OK;
        idx_d    = CntW'(1);
        case (kind_q) inside
          KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
            if (is_full) begin
              status_d = STATUS_FULL;
            end else begin
              wr_en   = 1'b1;
              count_d = count_q + CntW'(1);
              if (front_side) begin
                wr_addr = (front_q == '0) ? IdxLast : front_q - IdxW'(1);
                front_d = wr_addr;
              end else begin
                wr_addr = ring_pos(front_q, count_q);
              end
            end
          end
          KIND_POP_FRONT, KIND_POP_BACK: begin
            if (is_empty) begin
              status_d = STATUS_EMPTY;
            end else begin
              count_d = count_q - CntW'(1);
              if (front_side) begin
                rd_addr = front_q;
                front_d = ring_pos(front_q, CntW'(1));
              end else begin
                rd_addr = ring_pos(front_q, count_q - CntW'(1));
              end
            end
          end
          KIND_SEARCH: begin
            rd_addr = front_q;
          end
          KIND_REVERSE: begin
            rev_d = ~rev_q;
          end
          default: begin
          end
        endcase
      end
      ST_POP_WAIT: begin
        popped_d = rd_data_q;
      end
      ST_SEARCH: begin
        if (rd_data_q == key_q) begin
          found_d = 1'b1;
        end
        if (idx_q != count_q) begin
          rd_addr = ring_pos(front_q, idx_q);
          idx_d   = idx_q + CntW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      front_q <= '0;
      count_q <= '0;
      rev_q   <= 1'b0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      count_q <= count_d;
      rev_q   <= rev_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_beat) begin
      kind_q <= kind_e'(s_axis_tuser_i);
      key_q  <= s_axis_tdata_i[KEY_WIDTH-1:0];
    end
    popped_q <= popped_d;
    found_q  <= found_d;
    status_q <= status_d;
  end

  // key store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= key_q;
    end
    rd_data_q <= mem[rd_addr];
  end

  assign m_axis_tdata_o = {CountFieldW'(count_q), status_q, found_q, KeyFieldW'(popped_q)};

  `ASSERT_RST(a_count_bound, clk_i, rst_ni, count_q <= CntFull, "count above capacity")
  `ASSERT_RST(a_full_status, clk_i, rst_ni,
              (m_axis_tvalid_o && status_q == STATUS_FULL) |-> is_full,
              "full status with free room")
  `ASSERT_RST(a_empty_status, clk_i, rst_ni,
              (m_axis_tvalid_o && status_q == STATUS_EMPTY) |-> (is_empty && popped_q == '0),
              "empty status on a nonempty deque")
  `ASSERT_RST(a_found_search, clk_i, rst_ni,
              (m_axis_tvalid_o && found_q) |-> (kind_q == KIND_SEARCH),
              "found set outside a search")

endmodule

`default_nettype wire
